/* src/assert_macros.svh */
// Assertion macros shared by the Zobrist hash RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/zph_pkg.sv */
// Shared types and constants for the Zobrist position hash.
// No dependencies; imported by every module of the block but zph_ram.
`timescale 1ns / 1ps

package zph_pkg;

  localparam int KEY_W    = 64;
  localparam int SQUARE_W = 6;
  localparam int PIECE_W  = 4;
  localparam int FUNC_W   = 2;

  // Row of the key table used for en passant targets
  localparam int EP_ROW = 12;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SQUARE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

  // Configuration port
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] REG_SIDE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WKS  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WQS  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BKS  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BQS  = 3'd4;

  // Decoded operation carried from front to back
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SQUARE,
    OP_FINISH
  } op_t;

  // Finish-time mixing flags
  typedef struct packed {
    logic ep;
    logic wtm;
    logic wks;
    logic wqs;
    logic bks;
    logic bqs;
  } fin_flags_t;

  typedef struct packed {
    op_t                 op;
    logic [SQUARE_W-1:0] square;
    logic [PIECE_W-1:0]  row;
    logic [KEY_W-1:0]    key;
    fin_flags_t          flags;
  } cmd_t;

  // Side and castling keys from the register file
  typedef struct packed {
    logic [KEY_W-1:0] side;
    logic [KEY_W-1:0] wks;
    logic [KEY_W-1:0] wqs;
    logic [KEY_W-1:0] bks;
    logic [KEY_W-1:0] bqs;
  } cfg_keys_t;

  // Back-end status for checking
  typedef struct packed {
    logic pop;
    logic s2_stall;
    logic fin_done;
    logic hash_zero;
  } back_status_t;

endpackage

/* src/zobrist_position_hash.sv */
// Top level of the Zobrist position hash: register file, front, queue and back.
// Depends on zph_pkg, zph_front, zph_queue, zph_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one item per clock when the result side keeps up: every item makes at
// most one access to the key table, which has one port, so loads, squares and
// finishes all flow at one per cycle. A finish passes the queue and stage 2,
// and its hash is held in the result register. A two-entry queue sits between
// decode and execute, and the result register lets a new item in while a hash
// waits to be taken. Keys are written with load items (func 0) into a
// TABLE_ROWS x SQUARES table that holds garbage until loaded; side and castling
// keys are 64-bit registers at byte addresses 0, 8, 16, 24 and 32 of the APB port.
module zobrist_position_hash import zph_pkg::*; #(
  parameter int SQUARES    = 64,
  parameter int TABLE_ROWS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // input items
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [FUNC_W-1:0]     func,
  input  logic [SQUARE_W-1:0]   square,
  input  logic [PIECE_W-1:0]    piece,
  input  logic [KEY_W-1:0]      key_value,
  input  logic                  en_passant_valid,
  input  logic                  white_to_move,
  input  logic                  white_king_side,
  input  logic                  white_queen_side,
  input  logic                  black_king_side,
  input  logic                  black_queen_side,
  // result items
  output logic                  hash_valid,
  input  logic                  hash_ready,
  output logic [KEY_W-1:0]      hash
);

  cfg_keys_t              keys;
  logic                   cfg_write;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   push_valid;
  logic                   push_ready;
  cmd_t                   push_data;
  logic                   pop_valid;
  logic                   pop_ready;
  cmd_t                   pop_data;
  back_status_t           status;

  // Register file
  assign pready    = 1'b1;
  assign reg_idx   = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_SIDE: keys.side <= pwdata;
        REG_WKS:  keys.wks  <= pwdata;
        REG_WQS:  keys.wqs  <= pwdata;
        REG_BKS:  keys.bks  <= pwdata;
        REG_BQS:  keys.bqs  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SIDE: prdata = keys.side;
      REG_WKS:  prdata = keys.wks;
      REG_WQS:  prdata = keys.wqs;
      REG_BKS:  prdata = keys.bks;
      REG_BQS:  prdata = keys.bqs;
      default:  prdata = '0;
    endcase
  end

  // Decode front
  zph_front #(
    .SQUARES    (SQUARES),
    .TABLE_ROWS (TABLE_ROWS)
  ) u_front (
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .func             (func),
    .square           (square),
    .piece            (piece),
    .key_value        (key_value),
    .en_passant_valid (en_passant_valid),
    .white_to_move    (white_to_move),
    .white_king_side  (white_king_side),
    .white_queen_side (white_queen_side),
    .black_king_side  (black_king_side),
    .black_queen_side (black_queen_side),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_data        (push_data)
  );

  // Command queue
  zph_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Execute back
  zph_back #(
    .SQUARES    (SQUARES),
    .TABLE_ROWS (TABLE_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .keys       (keys),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash       (hash),
    .status     (status)
  );

  // Checks
  `ASSERT_IMPLIES(a_no_pop_on_stall, status.s2_stall, !status.pop, "pop while stage 2 stalled")
  `ASSERT_NEXT(a_fin_gives_hash, status.fin_done, hash_valid, "finish without result")
  `ASSERT_NEXT(a_fin_clears, status.fin_done, status.hash_zero, "running hash not cleared")

endmodule

/* src/zph_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module zph_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 832
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; read data holds while en is low and on a write
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* src/zph_queue.sv */
// Two-entry command queue between the decode front and the execute back.
// Depends on zph_pkg for cmd_t.
`timescale 1ns / 1ps

module zph_queue import zph_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* src/zph_front.sv */
// Input front end: range checks and classifies items into queue commands.
// Depends on zph_pkg.
`timescale 1ns / 1ps

module zph_front import zph_pkg::*; #(
  parameter int SQUARES    = 64,
  parameter int TABLE_ROWS = 13
) (
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [SQUARE_W-1:0] square,
  input  logic [PIECE_W-1:0]  piece,
  input  logic [KEY_W-1:0]    key_value,
  input  logic                en_passant_valid,
  input  logic                white_to_move,
  input  logic                white_king_side,
  input  logic                white_queen_side,
  input  logic                black_king_side,
  input  logic                black_queen_side,
  output logic                push_valid,
  input  logic                push_ready,
  output cmd_t                push_data
);

  localparam bit EP_ROW_PRESENT = (TABLE_ROWS > EP_ROW);

  logic square_ok;
  logic slot_ok;
  logic keep;

  assign square_ok = (32'(square) < SQUARES);
  assign slot_ok   = square_ok && (32'(piece) < TABLE_ROWS);

  // Decode; out-of-range slots and the unused code are dropped on accept
  always_comb begin
    keep           = 1'b0;
    push_data      = '0;
    push_data.op   = OP_SQUARE;
    push_data.square = square;
    push_data.row  = piece;
    push_data.key  = key_value;
    case (func)
      FUNC_LOAD: begin
        keep         = slot_ok;
        push_data.op = OP_LOAD;
      end
      FUNC_SQUARE: begin
        keep         = slot_ok;
        push_data.op = OP_SQUARE;
      end
      FUNC_FINISH: begin
        keep               = 1'b1;
        push_data.op       = OP_FINISH;
        push_data.row      = PIECE_W'(EP_ROW);
        push_data.flags.ep = en_passant_valid && square_ok && EP_ROW_PRESENT;
        push_data.flags.wtm = white_to_move;
        push_data.flags.wks = white_king_side;
        push_data.flags.wqs = white_queen_side;
        push_data.flags.bks = black_king_side;
        push_data.flags.bqs = black_queen_side;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item_ready = push_ready;
  assign push_valid = item_valid && keep;

endmodule

/* src/zph_back.sv */
// Execute back end: key table access, running hash and result register.
// Depends on zph_pkg and zph_ram.
`timescale 1ns / 1ps

module zph_back import zph_pkg::*; #(
  parameter int SQUARES    = 64,
  parameter int TABLE_ROWS = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  cmd_t             pop_data,
  input  cfg_keys_t        keys,
  output logic             hash_valid,
  input  logic             hash_ready,
  output logic [KEY_W-1:0] hash,
  output back_status_t     status
);

  localparam int DEPTH  = TABLE_ROWS * SQUARES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [31:0]       addr_full;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_en;
  logic              ram_we;
  logic [KEY_W-1:0]  ram_rdata;
  logic              pop;

  logic              s2_valid;
  op_t               s2_op;
  fin_flags_t        s2_flags;
  logic              s2_use_key;
  logic              s2_done;
  logic              out_free;
  logic              fin_done;
  logic [KEY_W-1:0]  s2_key;
  logic [KEY_W-1:0]  fin_hash;
  logic [KEY_W-1:0]  running_hash;

  // Stage 1: table address and access
  assign addr_full = 32'(pop_data.row) * SQUARES + 32'(pop_data.square);
  assign ram_addr  = addr_full[ADDR_W-1:0];

  assign out_free  = !hash_valid || hash_ready;
  assign s2_done   = s2_valid && ((s2_op != OP_FINISH) || out_free);
  assign fin_done  = s2_valid && (s2_op == OP_FINISH) && out_free;
  assign pop_ready = !s2_valid || s2_done;
  assign pop       = pop_valid && pop_ready;

  assign ram_we = (pop_data.op == OP_LOAD);
  assign ram_en = pop && ((pop_data.op == OP_LOAD) || (pop_data.op == OP_SQUARE) ||
                          ((pop_data.op == OP_FINISH) && pop_data.flags.ep));

  zph_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_key_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pop_data.key),
    .rdata (ram_rdata)
  );

  // Stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (pop_ready) begin
      s2_valid <= pop_valid && (pop_data.op != OP_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_op      <= pop_data.op;
      s2_flags   <= pop_data.flags;
      s2_use_key <= (pop_data.op == OP_SQUARE) || pop_data.flags.ep;
    end
  end

  // Stage 2 datapath
  assign s2_key = s2_use_key ? ram_rdata : '0;

  always_comb begin
    fin_hash = running_hash ^ s2_key;
    if (s2_flags.wtm) fin_hash = fin_hash ^ keys.side;
    if (s2_flags.wks) fin_hash = fin_hash ^ keys.wks;
    if (s2_flags.wqs) fin_hash = fin_hash ^ keys.wqs;
    if (s2_flags.bks) fin_hash = fin_hash ^ keys.bks;
    if (s2_flags.bqs) fin_hash = fin_hash ^ keys.bqs;
  end

  // Running hash
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (fin_done) begin
      running_hash <= '0;
    end else if (s2_valid && (s2_op == OP_SQUARE)) begin
      running_hash <= running_hash ^ s2_key;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (fin_done) begin
      hash_valid <= 1'b1;
    end else if (hash_ready) begin
      hash_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_done) begin
      hash <= fin_hash;
    end
  end

  assign status.pop       = pop;
  assign status.s2_stall  = s2_valid && !s2_done;
  assign status.fin_done  = fin_done;
  assign status.hash_zero = (running_hash == '0);

endmodule

/* test/zph_hash_checker.sv */
// Checker for the Zobrist position hash: watches the APB port and both item channels,
// predicts every hash and compares it. Depends on zph_pkg.
`timescale 1ns / 1ps

module zph_hash_checker import zph_pkg::*; #(
  parameter int SQUARES    = 64,
  parameter int TABLE_ROWS = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  logic [FUNC_W-1:0]     func,
  input  logic [SQUARE_W-1:0]   square,
  input  logic [PIECE_W-1:0]    piece,
  input  logic [KEY_W-1:0]      key_value,
  input  logic                  en_passant_valid,
  input  logic                  white_to_move,
  input  logic                  white_king_side,
  input  logic                  white_queen_side,
  input  logic                  black_king_side,
  input  logic                  black_queen_side,
  input  logic                  hash_valid,
  input  logic                  hash_ready,
  input  logic [KEY_W-1:0]      hash,
  output int                    mismatches,
  output int                    pending
);

  // Own copy of the block state
  logic [KEY_W-1:0] key_mem [TABLE_ROWS*SQUARES];
  logic [KEY_W-1:0] mix_key [REG_SIDE:REG_BQS];
  logic [KEY_W-1:0] board_hash;
  logic [KEY_W-1:0] expected_hashes [$];

  function automatic int slot(input int row, input int col);
    return row * SQUARES + col;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  // Apply one accepted item to the tracked state; a finish queues its hash
  task automatic advance_position_hash();
    logic [KEY_W-1:0] h;
    case (func)
      FUNC_LOAD: begin
        if (piece < TABLE_ROWS && square < SQUARES)
          key_mem[slot(piece, square)] = key_value;
      end
      FUNC_SQUARE: begin
        if (piece < TABLE_ROWS && square < SQUARES)
          board_hash ^= key_mem[slot(piece, square)];
      end
      FUNC_FINISH: begin
        h = board_hash;
        if (en_passant_valid && EP_ROW < TABLE_ROWS && square < SQUARES)
          h ^= key_mem[slot(EP_ROW, square)];
        if (white_to_move)    h ^= mix_key[REG_SIDE];
        if (white_king_side)  h ^= mix_key[REG_WKS];
        if (white_queen_side) h ^= mix_key[REG_WQS];
        if (black_king_side)  h ^= mix_key[REG_BKS];
        if (black_queen_side) h ^= mix_key[REG_BQS];
        expected_hashes.push_back(h);
        board_hash = '0;
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  initial begin
    foreach (key_mem[i]) key_mem[i] = '0;
  end

  always @(posedge clk) begin
    logic [REG_IDX_W-1:0] idx;
    logic [KEY_W-1:0]     want;
    idx = paddr[CFG_ADDR_W-1:3];
    if (rst) begin
      board_hash = '0;
      foreach (mix_key[i]) mix_key[i] = '0;
      expected_hashes.delete();
    end else begin
      // Register access phase
      if (psel && penable && pready && idx <= REG_BQS) begin
        if (pwrite)
          mix_key[idx] = pwdata;
        else if (prdata !== mix_key[idx])
          report_mismatch($sformatf("register %0d read %h, holds %h",
                                    idx, prdata, mix_key[idx]));
      end
      if (item_valid && item_ready) advance_position_hash();
      // Result side
      if (hash_valid && hash_ready) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch($sformatf("hash %h with no finish outstanding", hash));
        end else begin
          want = expected_hashes.pop_front();
          if (hash !== want)
            report_mismatch($sformatf("hash %h, predicted %h", hash, want));
        end
      end
    end
    pending <= expected_hashes.size();
  end

endmodule

/* test/tb_zobrist_position_hash.sv */
// Testbench top for the Zobrist position hash: clock, reset, APB key setup and item stimulus.
// Depends on zph_pkg, zobrist_position_hash and zph_hash_checker.
`timescale 1ns / 1ps

module tb_zobrist_position_hash import zph_pkg::*;;

  localparam int SQUARES    = 64;
  localparam int TABLE_ROWS = 13;
  localparam int SETTLE     = 16;  // cycles for non-result items to clear the pipe
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  item_valid;
  logic                  item_ready;
  logic [FUNC_W-1:0]     func;
  logic [SQUARE_W-1:0]   square;
  logic [PIECE_W-1:0]    piece;
  logic [KEY_W-1:0]      key_value;
  logic                  en_passant_valid;
  logic                  white_to_move;
  logic                  white_king_side;
  logic                  white_queen_side;
  logic                  black_king_side;
  logic                  black_queen_side;
  logic                  hash_valid;
  logic                  hash_ready;
  logic [KEY_W-1:0]      hash;

  int mismatches;
  int hashes_pending;
  int idle_pct;
  int stall_pct;
  int items_sent;
  bit loaded [TABLE_ROWS*SQUARES];

  zobrist_position_hash #(
    .SQUARES   (SQUARES),
    .TABLE_ROWS(TABLE_ROWS)
  ) u_top (.*);

  zph_hash_checker #(
    .SQUARES   (SQUARES),
    .TABLE_ROWS(TABLE_ROWS)
  ) u_checker (
    .*,
    .mismatches(mismatches),
    .pending   (hashes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result-side backpressure
  always @(posedge clk) begin
    hash_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [KEY_W-1:0] random_key();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic fin_flags_t random_flags();
    return fin_flags_t'(6'($urandom));
  endfunction

  // Mostly piece rows, now and then the en passant row
  function automatic int piece_row();
    return ($urandom_range(9) == 0) ? EP_ROW : $urandom_range(11);
  endfunction

  function automatic int slot(input int row, input int col);
    return row * SQUARES + col;
  endfunction

  task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [KEY_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write the side and castling keys, then read them all back
  task automatic program_mix_keys(input cfg_keys_t k);
    apb_access(1'b1, REG_SIDE, k.side);
    apb_access(1'b1, REG_WKS, k.wks);
    apb_access(1'b1, REG_WQS, k.wqs);
    apb_access(1'b1, REG_BKS, k.bks);
    apb_access(1'b1, REG_BQS, k.bqs);
    for (int i = REG_SIDE; i <= REG_BQS; i++)
      apb_access(1'b0, REG_IDX_W'(i), random_key());
  endtask

  // One item on the input channel; valid stays up until accepted
  task automatic send_item(input logic [FUNC_W-1:0] f, input int row, input int sq,
                           input logic [KEY_W-1:0] k, input fin_flags_t fl);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid       <= 1'b1;
    func             <= f;
    square           <= SQUARE_W'(sq);
    piece            <= PIECE_W'(row);
    key_value        <= k;
    en_passant_valid <= fl.ep;
    white_to_move    <= fl.wtm;
    white_king_side  <= fl.wks;
    white_queen_side <= fl.wqs;
    black_king_side  <= fl.bks;
    black_queen_side <= fl.bqs;
    do @(posedge clk); while (!item_ready);
    if (f == FUNC_FINISH || (f != FUNC_UNUSED && row < TABLE_ROWS)) items_sent++;
  endtask

  task automatic load_key(input int row, input int sq, input logic [KEY_W-1:0] k);
    send_item(FUNC_LOAD, row, sq, k, random_flags());
    if (row < TABLE_ROWS) loaded[slot(row, sq)] = 1'b1;
  endtask

  // Never touch an unwritten key: load it first
  task automatic place_piece(input int row, input int sq);
    if (!loaded[slot(row, sq)]) load_key(row, sq, random_key());
    send_item(FUNC_SQUARE, row, sq, random_key(), random_flags());
  endtask

  task automatic finish_position(input fin_flags_t fl, input int sq);
    if (fl.ep && !loaded[slot(EP_ROW, sq)]) load_key(EP_ROW, sq, random_key());
    send_item(FUNC_FINISH, $urandom_range(15), sq, random_key(), fl);
  endtask

  // Hold off until every hash is out and the pipe is quiet
  task automatic drain_hashes();
    item_valid <= 1'b0;
    @(posedge clk);
    while (hashes_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    cfg_keys_t  keys;
    fin_flags_t fl;
    int         target;
    int         pause_at;
    bit         paused;
    int         pick;

    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    item_valid       <= 1'b0;
    func             <= FUNC_LOAD;
    square           <= '0;
    piece            <= '0;
    key_value        <= '0;
    en_passant_valid <= 1'b0;
    white_to_move    <= 1'b0;
    white_king_side  <= 1'b0;
    white_queen_side <= 1'b0;
    black_king_side  <= 1'b0;
    black_queen_side <= 1'b0;
    hash_ready       <= 1'b0;
    stall_pct        <= 0;
    idle_pct   = 0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every function, corner cases
    keys = '{random_key(), random_key(), random_key(), random_key(), random_key()};
    program_mix_keys(keys);
    load_key(0, 0, '0);
    load_key(11, SQUARES - 1, '1);
    load_key(EP_ROW, SQUARES - 1, random_key());
    load_key(EP_ROW, 0, random_key());
    load_key(5, 17, random_key());
    send_item(FUNC_LOAD, 15, 10, random_key(), random_flags());   // row off the table
    place_piece(0, 0);
    place_piece(11, SQUARES - 1);
    place_piece(EP_ROW, 0);                                       // en passant row as a piece
    place_piece(5, 17);
    send_item(FUNC_SQUARE, TABLE_ROWS, 5, random_key(), random_flags());
    send_item(FUNC_UNUSED, 15, SQUARES - 1, '1, '1);
    finish_position('1, SQUARES - 1);                             // every key mixed in
    finish_position('0, 0);                                       // empty board
    place_piece(11, SQUARES - 1);
    place_piece(11, SQUARES - 1);                                 // same key twice cancels
    fl = '0; fl.ep = 1'b1; fl.wtm = 1'b1;
    finish_position(fl, 0);
    fl = '0; fl.wks = 1'b1; fl.bqs = 1'b1;
    finish_position(fl, 30);                                      // target ignored, ep off
    fl = '0; fl.wqs = 1'b1; fl.bks = 1'b1;
    finish_position(fl, 45);

    // Random positions under four idle/stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      drain_hashes();
      case (phase)
        0: begin
          idle_pct = 0;  stall_pct <= 0;
          keys = '{random_key(), random_key(), random_key(), random_key(), random_key()};
        end
        1: begin
          idle_pct = 63; stall_pct <= 0;
          keys = '1;
        end
        2: begin
          idle_pct = 0;  stall_pct <= 63;
          keys = '0;
        end
        default: begin
          idle_pct = 20; stall_pct <= 20;
          keys = '{random_key(), random_key(), random_key(), random_key(), random_key()};
        end
      endcase
      program_mix_keys(keys);
      target   = items_sent + 400;
      pause_at = items_sent + 200;
      paused   = 1'b0;
      while (items_sent < target) begin
        if (!paused && items_sent >= pause_at) begin
          drain_hashes();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 78) begin
          // Well-formed position
          repeat ($urandom_range(12)) place_piece(piece_row(), $urandom_range(SQUARES - 1));
          finish_position(random_flags(), $urandom_range(SQUARES - 1));
        end else if (pick < 86) begin
          load_key($urandom_range(EP_ROW), $urandom_range(SQUARES - 1), random_key());
        end else if (pick < 94) begin
          // Noise: unused code or rows off the table
          if ($urandom_range(1))
            send_item(FUNC_UNUSED, $urandom_range(15), $urandom_range(SQUARES - 1),
                      random_key(), random_flags());
          else
            send_item($urandom_range(1) ? FUNC_LOAD : FUNC_SQUARE,
                      $urandom_range(15, TABLE_ROWS), $urandom_range(SQUARES - 1),
                      random_key(), random_flags());
        end else begin
          // Broken sequence: pieces carried into the next position
          repeat ($urandom_range(4, 1)) place_piece(piece_row(), $urandom_range(SQUARES - 1));
        end
      end
    end

    drain_hashes();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
